// ----- rtl/page_table_translate_alloc_defines.svh -----
// Assertion macros shared by the page table checker.
// Include-guarded; holds macro definitions only.
`ifndef PAGE_TABLE_TRANSLATE_ALLOC_DEFINES_SVH
`define PAGE_TABLE_TRANSLATE_ALLOC_DEFINES_SVH

// Clocked assertion, disabled while reset is active.
`define PTA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, for a property that must hold only when the result channel shows a transaction.
`define PTA_ASSERT_OUT(lbl, clk, rstn, vld, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (vld) |-> (prop)) else $error(msg);

`endif

// ----- rtl/pta_pkg.sv -----
// Types and constants for the page table translate/allocate block.
// No dependencies; imported by the top level, its checker and the testbench.
`timescale 1ns / 1ps

package pta_pkg;

    localparam int VA_W      = 64;
    localparam int PA_W      = 64;
    localparam int VPN_W     = 58;
    localparam int CMD_W     = 2;
    localparam int CFG_W     = 5;
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 72;

    localparam logic [CFG_W-1:0] SHIFT_MIN   = 5'd6;
    localparam logic [CFG_W-1:0] SHIFT_MAX   = 5'd30;
    localparam logic [CFG_W-1:0] SHIFT_RESET = 5'd12;

    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_RESOLVE
    } state_t;

endpackage

// ----- rtl/page_table_translate_alloc.sv -----
// Page table with first-touch allocation: sequential tag search, one entry per cycle.
// A new transaction is accepted only after the previous one has left resolve; s_tready is high only
// between items, and a stalled result holds the item after it in resolve.
// Reset (aresetn low, sync) empties the table, clears the allocator, sets page_size_log2
// to 12; no clearing pass. Depends on pta_pkg.
`timescale 1ns / 1ps

module page_table_translate_alloc
    import pta_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,   // page_size_log2
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // virt_addr[63:0], fill_phys_page_start[127:64]
    input  logic [CMD_W-1:0]     s_tuser,       // cmd[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // phys_addr[63:0], was_mapped[64],
                                                // newly_allocated[65], table_full[66], zero pad
);

    localparam int IDXW = $clog2(TABLE_ENTRIES);
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNTW-1:0] ENTRIES_CNT = CNTW'(TABLE_ENTRIES);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] cfg_shift_reg;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [VA_W-1:0]  va_reg, va_next;
    logic [PA_W-1:0]  fill_reg, fill_next;
    logic [VPN_W-1:0] vpn_reg, vpn_next;
    logic [CNTW-1:0]  scan_ptr_reg, scan_ptr_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDXW-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [VPN_W-1:0] tag_q_reg;
    logic             hit_reg, hit_next;
    logic [IDXW-1:0]  hit_idx_reg, hit_idx_next;
    logic [PA_W-1:0]  phys_q_reg;
    logic [CNTW-1:0]  used_reg, used_next;
    logic [PA_W-1:0]  next_free_reg, next_free_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [VPN_W-1:0] tag_mem  [TABLE_ENTRIES];
    logic [PA_W-1:0]  phys_mem [TABLE_ENTRIES];

    logic             mem_we;
    logic [PA_W-1:0]  mem_wr_phys;

    logic [CFG_W-1:0] eff_shift;
    logic [PA_W-1:0]  page_size;
    logic [VA_W-1:0]  page_mask;
    logic             tag_match;
    logic             scan_done;
    logic             out_free;
    logic             room;
    logic [PA_W-1:0]  add_base;
    logic [PA_W-1:0]  add_sum;

    // Clamp the configured page size into the supported range.
    always_comb begin
        if (cfg_shift_reg < SHIFT_MIN) begin
            eff_shift = SHIFT_MIN;
        end else if (cfg_shift_reg > SHIFT_MAX) begin
            eff_shift = SHIFT_MAX;
        end else begin
            eff_shift = cfg_shift_reg;
        end
    end

    assign page_size = PA_W'(1) << eff_shift;
    assign page_mask = page_size - PA_W'(1);
    assign tag_match = cmp_vld_reg && (tag_q_reg == vpn_reg);
    assign scan_done = !cmp_vld_reg && (scan_ptr_reg >= used_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign room      = used_reg < ENTRIES_CNT;
    assign add_base  = hit_reg ? phys_q_reg : next_free_reg;
    assign add_sum   = add_base + (va_reg & page_mask);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (tag_match) begin
                    state_next = ST_READ;
                end else if (scan_done) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_READ: begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        cmd_next       = cmd_reg;
        va_next        = va_reg;
        fill_next      = fill_reg;
        vpn_next       = vpn_reg;
        scan_ptr_next  = scan_ptr_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        used_next      = used_reg;
        next_free_next = next_free_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_wr_phys    = next_free_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next      = s_tuser;
                    va_next       = s_tdata[VA_W-1:0];
                    fill_next     = s_tdata[S_TDATA_W-1:VA_W];
                    vpn_next      = VPN_W'(s_tdata[VA_W-1:0] >> eff_shift);
                    scan_ptr_next = '0;
                    hit_next      = 1'b0;
                end
            end
            ST_SEARCH: begin
                // Issue one tag read per cycle; compare the one read last cycle.
                if (!tag_match && scan_ptr_reg < used_reg) begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_ptr_reg[IDXW-1:0];
                    scan_ptr_next = scan_ptr_reg + CNTW'(1);
                end
                if (tag_match) begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                end
            end
            ST_READ: begin
            end
            ST_RESOLVE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[PA_W] = hit_reg;
                    if (cmd_reg == CMD_TRANSLATE) begin
                        if (hit_reg) begin
                            m_tdata_next[PA_W-1:0] = add_sum;
                        end else if (room) begin
                            m_tdata_next[PA_W-1:0] = add_sum;
                            m_tdata_next[PA_W+1]   = 1'b1;
                            mem_we         = 1'b1;
                            mem_wr_phys    = next_free_reg;
                            used_next      = used_reg + CNTW'(1);
                            next_free_next = next_free_reg + page_size;
                        end else begin
                            m_tdata_next[PA_W+2] = 1'b1;
                        end
                    end else if (cmd_reg == CMD_FILL) begin
                        if (!hit_reg && room) begin
                            mem_we      = 1'b1;
                            mem_wr_phys = fill_reg;
                            used_next   = used_reg + CNTW'(1);
                        end else if (!hit_reg) begin
                            m_tdata_next[PA_W+2] = 1'b1;
                        end
                    end else begin
                        if (hit_reg) m_tdata_next[PA_W-1:0] = add_sum;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Entry memories: one write port, registered reads.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[used_reg[IDXW-1:0]]  <= vpn_reg;
            phys_mem[used_reg[IDXW-1:0]] <= mem_wr_phys;
        end
        tag_q_reg  <= tag_mem[scan_ptr_reg[IDXW-1:0]];
        phys_q_reg <= phys_mem[hit_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_shift_reg <= SHIFT_RESET;
            used_reg      <= '0;
            next_free_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            scan_ptr_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            if (cfg_wr_en) cfg_shift_reg <= cfg_wr_data;
            used_reg      <= used_next;
            next_free_reg <= next_free_next;
            m_tvalid_reg  <= m_tvalid_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            scan_ptr_reg  <= scan_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        va_reg      <= va_next;
        fill_reg    <= fill_next;
        vpn_reg     <= vpn_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ----- rtl/pta_checker.sv -----
// Port-level checker for the page table translate/allocate block, bound to the top level.
// Depends on pta_pkg and page_table_translate_alloc_defines.svh.
`timescale 1ns / 1ps
`include "page_table_translate_alloc_defines.svh"

module pta_checker
    import pta_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result transaction.
    `PTA_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The search takes cycles: no second transaction right after one is accepted.
    `PTA_ASSERT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "ready right after accept")

    // A hit never allocates, and a full table neither hits nor allocates.
    `PTA_ASSERT_OUT(a_flags_excl, aclk, aresetn, m_tvalid, !(m_tdata[PA_W+2] && (m_tdata[PA_W] || m_tdata[PA_W+1])) && !(m_tdata[PA_W] && m_tdata[PA_W+1]), "conflicting result flags")

    // A refused entry leaves no address.
    `PTA_ASSERT_OUT(a_full_zero, aclk, aresetn, m_tvalid && m_tdata[PA_W+2], m_tdata[PA_W-1:0] == '0, "nonzero address with table full")

endmodule

bind page_table_translate_alloc pta_checker u_pta_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for page_table_translate_alloc: streams translate, fill and
// query commands under several page sizes and stall patterns and checks every answer.
// Depends on pta_pkg and the page_table_translate_alloc RTL.
`timescale 1ns / 1ps

module tb_top;
    import pta_pkg::*;

    localparam int PT_ENTRIES = 64;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [VA_W-1:0]  va;
        logic [PA_W-1:0]  fill_pa;
    } lookup_t;

    // Same bit order as m_tdata[66:0].
    typedef struct packed {
        logic            full;
        logic            alloc;
        logic            mapped;
        logic [PA_W-1:0] phys;
    } answer_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // virt_addr[63:0], fill_phys_page_start[127:64]
    logic [CMD_W-1:0]     s_tuser = '0;    // cmd[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // phys_addr[63:0], was_mapped[64],
                                           // newly_allocated[65], table_full[66], zero pad

    page_table_translate_alloc #(
        .TABLE_ENTRIES(PT_ENTRIES)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Page table mirror
    logic [CFG_W-1:0] page_shift_cfg = SHIFT_RESET;
    logic [VPN_W-1:0] tbl_vpn [PT_ENTRIES];
    logic [PA_W-1:0]  tbl_phys [PT_ENTRIES];
    logic [PA_W-1:0]  alloc_ptr = '0;
    int unsigned      entries_used = 0;

    lookup_t          lookup_queue[$];
    answer_t          answer_queue[$];
    logic [VA_W-1:0]  seen_addrs[$];
    lookup_t          drv_item;
    logic             lookup_taken = 1'b0;

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned errors = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_mapped = 0;
    int unsigned n_alloc = 0;
    int unsigned n_full = 0;
    int unsigned n_shift_writes = 0;

    function automatic logic [CFG_W-1:0] page_shift();
        logic [CFG_W-1:0] sh;
        sh = page_shift_cfg;
        if (sh < SHIFT_MIN) sh = SHIFT_MIN;
        if (sh > SHIFT_MAX) sh = SHIFT_MAX;
        return sh;
    endfunction

    function automatic answer_t predict_lookup(logic [CMD_W-1:0] cmd, logic [VA_W-1:0] va,
                                               logic [PA_W-1:0] fill_pa);
        logic [CFG_W-1:0] sh;
        logic [PA_W-1:0]  psize;
        logic [VA_W-1:0]  offset;
        logic [VPN_W-1:0] vpn;
        int               hit;
        answer_t          r;
        sh = page_shift();
        psize = 64'd1 << sh;
        offset = va & (psize - 64'd1);
        vpn = VPN_W'(va >> sh);
        hit = -1;
        for (int i = 0; i < PT_ENTRIES; i++)
            if (hit < 0 && i < entries_used && tbl_vpn[i] == vpn) hit = i;
        r = '0;
        r.mapped = (hit >= 0);
        case (cmd)
            CMD_TRANSLATE: begin
                if (hit >= 0) begin
                    r.phys = tbl_phys[hit] + offset;
                end else if (entries_used < PT_ENTRIES) begin
                    tbl_vpn[entries_used] = vpn;
                    tbl_phys[entries_used] = alloc_ptr;
                    entries_used++;
                    r.phys = alloc_ptr + offset;
                    r.alloc = 1'b1;
                    alloc_ptr += psize;
                end else begin
                    r.full = 1'b1;
                end
            end
            CMD_FILL: begin
                if (hit < 0) begin
                    if (entries_used < PT_ENTRIES) begin
                        tbl_vpn[entries_used] = vpn;
                        tbl_phys[entries_used] = fill_pa;
                        entries_used++;
                    end else begin
                        r.full = 1'b1;
                    end
                end
            end
            default: begin
                // query, and the unused code behaves the same
                if (hit >= 0) r.phys = tbl_phys[hit] + offset;
            end
        endcase
        return r;
    endfunction

    function automatic void compare_field(string fname, logic [63:0] want, logic [63:0] seen);
        if (want !== seen) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, seen);
        end
    endfunction

    function automatic void queue_lookup(logic [CMD_W-1:0] cmd, logic [VA_W-1:0] va,
                                         logic [PA_W-1:0] fill_pa);
        lookup_queue.push_back('{cmd, va, fill_pa});
        seen_addrs.push_back(va);
    endfunction

    // Mostly revisit known pages with a fresh offset; now and then touch a new address.
    function automatic void queue_random_lookup();
        int unsigned      roll;
        logic [CMD_W-1:0] cmd;
        logic [VA_W-1:0]  va;
        logic [VA_W-1:0]  low_mask;
        roll = $urandom_range(99);
        if (roll < 50)      cmd = CMD_TRANSLATE;
        else if (roll < 70) cmd = CMD_FILL;
        else if (roll < 95) cmd = CMD_QUERY;
        else                cmd = CMD_UNUSED;
        if (seen_addrs.size() == 0 || $urandom_range(99) < 10) begin
            va = {$urandom, $urandom};
            seen_addrs.push_back(va);
        end else begin
            low_mask = (64'd1 << page_shift()) - 64'd1;
            va = seen_addrs[$urandom_range(seen_addrs.size() - 1)];
            va = (va & ~low_mask) | ({$urandom, $urandom} & low_mask);
        end
        lookup_queue.push_back('{cmd, va, {$urandom, $urandom}});
    endfunction

    task automatic wait_idle();
        while (lookup_queue.size() != 0 || s_tvalid || answer_queue.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_page_shift(input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        page_shift_cfg = val;
        n_shift_writes++;
    endtask

    // Record each accepted transaction and predict its answer.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            answer_queue.push_back(predict_lookup(s_tuser, s_tdata[VA_W-1:0],
                                                  s_tdata[VA_W+PA_W-1:VA_W]));
            lookup_taken = 1'b1;
            n_accepted++;
        end
    end

    // Hold valid until the transaction is taken, then advance.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || lookup_taken) begin
            lookup_taken = 1'b0;
            if (lookup_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                drv_item = lookup_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {drv_item.fill_pa, drv_item.va};
                s_tuser <= drv_item.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        answer_t seen;
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata[$bits(answer_t)-1:0];
            if (answer_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            end else begin
                want = answer_queue.pop_front();
                compare_field("phys_addr", want.phys, seen.phys);
                compare_field("was_mapped", 64'(want.mapped), 64'(seen.mapped));
                compare_field("newly_allocated", 64'(want.alloc), 64'(seen.alloc));
                compare_field("table_full", 64'(want.full), 64'(seen.full));
                n_checked++;
                n_mapped += want.mapped;
                n_alloc += want.alloc;
                n_full += want.full;
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] shift_plan [PHASES];
        shift_plan = '{SHIFT_RESET, 5'd0, 5'd31, SHIFT_MIN, SHIFT_MAX,
                       CFG_W'($urandom_range(31)), 5'd7, SHIFT_RESET};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, hits, fill over an existing page, offset wrap,
        // unaligned fill start, the unused command code, extreme bit patterns.
        queue_lookup(CMD_QUERY,     64'h0,                  64'h0);
        queue_lookup(CMD_TRANSLATE, 64'h123,                64'h0);
        queue_lookup(CMD_TRANSLATE, 64'h456,                64'hFFFF_FFFF_FFFF_FFFF);
        queue_lookup(CMD_QUERY,     64'hFFF,                64'h0);
        queue_lookup(CMD_FILL,      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_lookup(CMD_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        queue_lookup(CMD_FILL,      64'h10,                 64'hDEAD_BEEF_0000_1000);
        queue_lookup(CMD_TRANSLATE, 64'h20,                 64'h0);
        queue_lookup(CMD_UNUSED,    64'h30,                 64'h0);
        queue_lookup(CMD_UNUSED,    64'h7000,               64'h0);
        queue_lookup(CMD_FILL,      64'h5000,               64'h5555_5555_5555_5555);
        queue_lookup(CMD_TRANSLATE, 64'h5ABC,               64'h0);
        queue_lookup(CMD_QUERY,     64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_lookup(CMD_TRANSLATE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0);
        queue_lookup(CMD_TRANSLATE, 64'h5555_5555_5555_5555, 64'h0);
        queue_lookup(CMD_FILL,      64'h8000,               64'h0);
        queue_lookup(CMD_QUERY,     64'h8FFF,               64'h0);

        for (int ph = 0; ph < PHASES; ph++) begin
            // Starve the block until every answer is back; change page size only then.
            wait_idle();
            if (ph != 0) begin
                repeat (8) @(posedge aclk);
                write_page_shift(shift_plan[ph]);
            end
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
                default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) queue_random_lookup();
        end

        wait_idle();
        repeat (80) @(posedge aclk);
        $display("Run: %0d commands accepted, %0d answers checked over %0d page size writes",
                 n_accepted, n_checked, n_shift_writes);
        $display("Answers: %0d hits, %0d allocations, %0d table-full refusals",
                 n_mapped, n_alloc, n_full);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d answers outstanding", answer_queue.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pta_pkg.sv
rtl/page_table_translate_alloc.sv
rtl/pta_checker.sv
sim/tb_top.sv
